// ----- hw/rtl/bffa_pkg.sv -----
`default_nettype none

package bffa_pkg;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef struct packed {
    logic        action;
    logic [9:0]  start_cell;
    logic [10:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_start;
  } resp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MARK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bffa_map_ram.sv -----
`default_nettype none

module bffa_map_ram #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic                          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_first_fit_allocator.sv -----
// Allocate: each cell scanned, up to POOL_CELLS, is read and then checked;
//   a fitting run is then marked cell by cell before the answer.
// Free: the run is cleared cell by cell before the answer; a rejected or
//   empty free answers without touching the map. One request is in work at a time.
// Reset clears control state, then a pass writes all POOL_CELLS cells of the
//   map free; req_ready stays low until the pass is done.
`default_nettype none

module bitmap_first_fit_allocator #(
  parameter int POOL_CELLS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire bffa_pkg::req_t  req,
  output logic                 resp_valid,
  input  wire logic            resp_ready,
  output bffa_pkg::resp_t      resp
);

  import bffa_pkg::*;

  localparam int AW = $clog2(POOL_CELLS);
  localparam int CW = $clog2(POOL_CELLS + 1);
  localparam int SW = (CW > 12) ? CW : 12;
  localparam logic [SW-1:0] POOL_S = SW'(POOL_CELLS);
  localparam logic [AW-1:0] LAST = AW'(POOL_CELLS - 1);

  state_t        state, state_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [SW-1:0] cnt, cnt_next;
  logic [SW-1:0] runlen, runlen_next;
  logic [AW-1:0] run_start, run_start_next;
  logic          action_q, action_q_next;
  logic [SW-1:0] len_q, len_q_next;
  logic [1:0]    status_q, status_q_next;
  logic [9:0]    granted_q, granted_q_next;
  logic          resp_valid_next;
  resp_t         resp_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  logic [SW-1:0] in_len;
  logic [SW-1:0] in_start;
  logic [SW-1:0] in_end;
  logic [SW-1:0] run_start_w;
  logic [SW-1:0] runlen_inc;

  assign in_len      = SW'(req.run_length);
  assign in_start    = SW'(req.start_cell);
  assign in_end      = in_start + in_len;
  assign run_start_w = SW'(run_start);
  assign runlen_inc  = runlen + SW'(1);

  bffa_map_ram #(
    .DEPTH(POOL_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      resp_valid <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      resp_valid <= resp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    runlen    <= runlen_next;
    run_start <= run_start_next;
    action_q  <= action_q_next;
    len_q     <= len_q_next;
    status_q  <= status_q_next;
    granted_q <= granted_q_next;
    resp      <= resp_next;
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    cnt_next        = cnt;
    runlen_next     = runlen;
    run_start_next  = run_start;
    action_q_next   = action_q;
    len_q_next      = len_q;
    status_q_next   = status_q;
    granted_q_next  = granted_q;
    resp_next       = resp;
    resp_valid_next = resp_valid && !resp_ready;
    req_ready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_wdata       = 1'b0;

    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ptr_next = ptr + AW'(1);
        if (ptr == LAST) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          action_q_next  = req.action;
          len_q_next     = in_len;
          status_q_next  = ST_DONE;
          granted_q_next = '0;
          state_next     = S_RESP;
          if (req.action == ACT_ALLOC) begin
            if (in_len == '0 || in_len > POOL_S) begin
              status_q_next = ST_NOFIT;
            end else begin
              ptr_next       = '0;
              runlen_next    = '0;
              run_start_next = '0;
              state_next     = S_READ;
            end
          end else if (in_end > POOL_S) begin
            status_q_next = ST_BEYOND;
          end else if (in_len != '0) begin
            ptr_next   = in_start[AW-1:0];
            cnt_next   = in_len;
            state_next = S_MARK;
          end
        end
      end

      S_READ: begin
        state_next = S_CHECK;
      end

      S_CHECK: begin
        if (ram_rdata) begin
          // A used cell breaks the run; the next candidate starts just past it.
          runlen_next    = '0;
          run_start_next = ptr + AW'(1);
        end else begin
          runlen_next = runlen_inc;
        end
        if (!ram_rdata && runlen_inc == len_q) begin
          granted_q_next = run_start_w[9:0];
          ptr_next       = run_start;
          cnt_next       = len_q;
          state_next     = S_MARK;
        end else if (ptr == LAST) begin
          status_q_next = ST_NOFIT;
          state_next    = S_RESP;
        end else begin
          ptr_next   = ptr + AW'(1);
          state_next = S_READ;
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (action_q == ACT_ALLOC);
        ptr_next  = ptr + AW'(1);
        cnt_next  = cnt - SW'(1);
        if (cnt == SW'(1)) begin
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (!resp_valid || resp_ready) begin
          resp_next.status        = status_q;
          resp_next.granted_start = granted_q;
          resp_valid_next         = 1'b1;
          ptr_next                = '0;
          state_next              = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bffa_checker.sv -----
`default_nettype none

module bffa_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire bffa_pkg::req_t  req,
  input wire logic            resp_valid,
  input wire logic            resp_ready,
  input wire bffa_pkg::resp_t resp
);

  import bffa_pkg::*;

  // A held response must not change under backpressure.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp))
    else $error("response changed while stalled");

  // The map is being cleared right after reset, so no request is taken.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready && !resp_valid)
    else $error("block ready or answering right after reset");

  // Only a successful allocation reports a nonzero start.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status != ST_DONE |-> resp.granted_start == '0)
    else $error("granted start set on a failed request");

  // Once a request is taken the block is not ready again in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready again right after accepting a request");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (.*);

`default_nettype wire

// ----- test/bffa_reply_checker.sv -----
`timescale 1ns / 1ps

module bffa_reply_checker #(
  parameter int POOL_CELLS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  bffa_pkg::req_t   req,
  input  logic             resp_valid,
  input  logic             resp_ready,
  input  bffa_pkg::resp_t  resp,
  output int               errors,
  output int               pending,
  output int               grants,
  output int               no_fits,
  output int               rejected_frees
);
  import bffa_pkg::*;

  bit [POOL_CELLS-1:0] cell_used;
  resp_t expected_replies[$];
  int error_tally;
  int grant_tally;
  int nofit_tally;
  int beyond_tally;

  // Applies one request to the shadow map and returns the reply it must produce.
  function automatic resp_t serve_request(input req_t r);
    resp_t o;
    int len;
    int run;
    int first;
    o.status = ST_DONE;
    o.granted_start = '0;
    len = int'(r.run_length);
    if (action_t'(r.action) == ACT_ALLOC) begin
      o.status = ST_NOFIT;
      if (len != 0 && len <= POOL_CELLS) begin
        run = 0;
        for (int i = 0; i < POOL_CELLS; i++) begin
          if (cell_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == len) begin
              first = i + 1 - len;
              for (int k = 0; k < len; k++) cell_used[first + k] = 1'b1;
              o.status = ST_DONE;
              o.granted_start = first[9:0];
              break;
            end
          end
        end
      end
    end else if (int'(r.start_cell) + len > POOL_CELLS) begin
      o.status = ST_BEYOND;
    end else begin
      for (int k = 0; k < len; k++) cell_used[int'(r.start_cell) + k] = 1'b0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      cell_used = '0;
      expected_replies.delete();
      error_tally = 0;
      grant_tally = 0;
      nofit_tally = 0;
      beyond_tally = 0;
    end else begin
      // Replies are handled first, so a request accepted on the same edge
      // cannot stand in for a missing one.
      if (resp_valid && resp_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply (status %0d, granted_start %0d) with no request outstanding",
                 resp.status, resp.granted_start);
          error_tally++;
        end else begin
          want = expected_replies.pop_front();
          if (resp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, resp.status);
            error_tally++;
          end
          if (resp.granted_start !== want.granted_start) begin
            $error("granted_start: expected %0d, got %0d",
                   want.granted_start, resp.granted_start);
            error_tally++;
          end
        end
      end
      if (req_valid && req_ready) begin
        want = serve_request(req);
        expected_replies = {expected_replies, want};
        if (want.status == ST_NOFIT) nofit_tally++;
        else if (want.status == ST_BEYOND) beyond_tally++;
        else if (action_t'(req.action) == ACT_ALLOC) grant_tally++;
      end
    end
    errors <= error_tally;
    pending <= expected_replies.size();
    grants <= grant_tally;
    no_fits <= nofit_tally;
    rejected_frees <= beyond_tally;
  end

endmodule

// ----- test/tb_bitmap_first_fit_allocator.sv -----
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator;
  import bffa_pkg::*;

  localparam int POOL_CELLS = 1024;
  localparam int HOLDOFF_CYCLES = 400;
  // Longest request: a full scan, reading and checking each cell, plus marking the pool.
  localparam int SETTLE_CYCLES = 3 * POOL_CELLS + 200;
  localparam int PHASE_REQUESTS = 90;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  resp_valid;
  logic  resp_ready;
  resp_t resp;

  int error_count;
  int pending_count;
  int grant_count;
  int nofit_count;
  int beyond_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int issued;
  bit hold_responses;

  bitmap_first_fit_allocator #(
    .POOL_CELLS(POOL_CELLS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  bffa_reply_checker #(
    .POOL_CELLS(POOL_CELLS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .resp_valid     (resp_valid),
    .resp_ready     (resp_ready),
    .resp           (resp),
    .errors         (error_count),
    .pending        (pending_count),
    .grants         (grant_count),
    .no_fits        (nofit_count),
    .rejected_frees (beyond_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Response side: random back-pressure, plus one long hold-off on demand.
  initial begin
    resp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_responses) begin
        hold_responses = 1'b0;
        resp_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      resp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic send_request(input req_t r);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    issued++;
  endtask

  task automatic request_run(input action_t act, input int first, input int len);
    req_t r;
    r.action = act;
    r.start_cell = first[9:0];
    r.run_length = len[10:0];
    send_request(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Mostly small allocations and frees of random ranges keep the pool fragmented;
  // a few oversized, empty and boundary-crossing requests are mixed in.
  function automatic req_t random_request();
    req_t r;
    int pick;
    r.start_cell = 10'($urandom_range(POOL_CELLS - 1));
    pick = $urandom_range(99);
    if (pick < 58) begin
      r.action = ACT_ALLOC;
      pick = $urandom_range(99);
      if (pick < 70) r.run_length = 11'($urandom_range(16, 1));
      else if (pick < 90) r.run_length = 11'($urandom_range(128, 17));
      else if (pick < 96) r.run_length = 11'($urandom_range(POOL_CELLS, 129));
      else if (pick < 98) r.run_length = '0;
      else r.run_length = 11'($urandom_range(2047, POOL_CELLS + 1));
    end else begin
      r.action = ACT_FREE;
      if ($urandom_range(99) < 15) r.start_cell = 10'($urandom_range(POOL_CELLS - 1, 990));
      pick = $urandom_range(99);
      if (pick < 60) r.run_length = 11'($urandom_range(32, 1));
      else if (pick < 85) r.run_length = 11'($urandom_range(256, 33));
      else if (pick < 92) r.run_length = 11'($urandom_range(POOL_CELLS, 257));
      else if (pick < 96) r.run_length = '0;
      else r.run_length = 11'($urandom_range(2047, POOL_CELLS + 1));
    end
    return r;
  endfunction

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int count,
                                  input bit with_holdoff);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (with_holdoff && i == count / 2) hold_responses = 1'b1;
      send_request(random_request());
    end
    wait_drained();
  endtask

  initial begin
    req_valid <= 1'b0;
    req <= '0;
    rst <= 1'b1;
    tx_idle_pct = 12;
    rx_idle_pct = 59;
    issued = 0;
    hold_responses = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    request_run(ACT_ALLOC, 0, 0);
    request_run(ACT_ALLOC, 0, POOL_CELLS + 1);
    request_run(ACT_ALLOC, 1023, 2047);
    request_run(ACT_ALLOC, 0, POOL_CELLS);
    request_run(ACT_ALLOC, 0, 1);
    request_run(ACT_FREE, 1023, 2);
    request_run(ACT_FREE, 0, POOL_CELLS);
    request_run(ACT_FREE, 1023, 1);
    request_run(ACT_FREE, 5, 0);
    request_run(ACT_FREE, 1023, 2047);
    request_run(ACT_ALLOC, 0, POOL_CELLS - 1);
    request_run(ACT_ALLOC, 0, 1);
    request_run(ACT_FREE, 1, 3);
    request_run(ACT_ALLOC, 0, 2);
    request_run(ACT_ALLOC, 0, 2);
    request_run(ACT_ALLOC, 0, 1);
    request_run(ACT_FREE, 0, POOL_CELLS);
    request_run(ACT_ALLOC, 0, 1);
    request_run(ACT_ALLOC, 0, 3);
    // The remaining free run ends exactly at the last cell.
    request_run(ACT_ALLOC, 0, POOL_CELLS - 4);
    request_run(ACT_FREE, 0, POOL_CELLS);
    wait_drained();

    run_random_phase(12, 59, PHASE_REQUESTS, 1'b1);
    run_random_phase(59, 12, PHASE_REQUESTS, 1'b0);
    run_random_phase(0, 0, PHASE_REQUESTS, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d allocations granted, %0d found no fitting run,",
             issued, grant_count, nofit_count);
    $display("%0d frees rejected past the pool end; directed corners plus three idle mixes.",
             beyond_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_map_ram.sv
hw/rtl/bitmap_first_fit_allocator.sv
hw/rtl/bffa_checker.sv
test/bffa_reply_checker.sv
test/tb_bitmap_first_fit_allocator.sv
